// ===== hw/rtl/das_pkg.sv =====
// Shared types and constants for the dynamic array stack.
// Used by das_ctrl, das_store, the top level and the checker.
package das_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 11;
  localparam int unsigned CapW    = 12;
  localparam int unsigned ResizeW = 32;

  localparam int unsigned StoreDepthDefault = 1024;

  // Entry count never goes past this, whatever the store depth.
  localparam int unsigned CountMax = 2047;

  localparam logic [CapW-1:0] CapReset = CapW'(16);
  localparam logic [CapW-1:0] CapMax   = CapW'(4095);

  // Operation codes carried on kind
  localparam logic KindPush = 1'b0;
  localparam logic KindPop  = 1'b1;

  localparam logic [DataW-1:0] EmptyValue = '1;

  typedef struct packed {
    logic signed [DataW-1:0] popped_value;
    logic                    empty_flag;
    logic                    full_flag;
    logic [CountW-1:0]       count;
    logic [CapW-1:0]         capacity;
    logic [ResizeW-1:0]      resize_count;
  } result_t;

endpackage

// ===== hw/rtl/dynamic_array_stack_resizing.sv =====
// Stack over a fixed entry store with doubling/halving capacity bookkeeping.
// Instantiates das_ctrl and das_store; depends on das_pkg.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per
//   transaction: kind_i selects push of key_i or pop of the top entry.
//   Output channel (out_valid_o/out_ready_i) returns one result per
//   operation: popped value, empty and full flags, count, logical capacity
//   and the saturating resize counter, all as they stand after the operation.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes initial_capacity
//   from cfg_data_i, which loads the capacity and clears the count; write it
//   only while no operation is in flight.
// Timing:
//   A push or a pop of an empty stack has its result valid the cycle after
//   the transaction. A pop of a stored entry passes through StPopWait, where
//   the registered read data of the store is loaded into the result register.
//   The result register holds a result until taken; a new operation is taken
//   in the same cycle the held result leaves, and not while it stalls.
// Reset:
//   rst_ni clears count and resize counter and sets capacity to 16; the store
//   contents are not cleared.
module dynamic_array_stack_resizing #(
  parameter int unsigned STORE_DEPTH = das_pkg::StoreDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [das_pkg::CountW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [das_pkg::DataW-1:0]  key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [das_pkg::DataW-1:0]  popped_value_o,
  output logic                              empty_flag_o,
  output logic                              full_flag_o,
  output logic [das_pkg::CountW-1:0]        count_o,
  output logic [das_pkg::CapW-1:0]          capacity_o,
  output logic [das_pkg::ResizeW-1:0]       resize_count_o
);

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);

  das_pkg::result_t           res;
  logic                       mem_we;
  logic                       mem_re;
  logic [AddrW-1:0]           mem_addr;
  logic [das_pkg::DataW-1:0]  mem_wdata;
  logic [das_pkg::DataW-1:0]  mem_rdata;

  das_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  das_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign popped_value_o = res.popped_value;
  assign empty_flag_o   = res.empty_flag;
  assign full_flag_o    = res.full_flag;
  assign count_o        = res.count;
  assign capacity_o     = res.capacity;
  assign resize_count_o = res.resize_count;

endmodule

// ===== hw/rtl/das_store.sv =====
// Entry store: single-port synchronous RAM with a registered read.
// Depends on das_pkg for the data width.
module das_store #(
  parameter int unsigned STORE_DEPTH = das_pkg::StoreDepthDefault,
  localparam int unsigned AddrW = $clog2(STORE_DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic                            re_i,
  input  logic [AddrW-1:0]                addr_i,
  input  logic [das_pkg::DataW-1:0]       wdata_i,
  output logic [das_pkg::DataW-1:0]       rdata_o
);

  logic [das_pkg::DataW-1:0] mem [STORE_DEPTH];
  logic [das_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/das_ctrl.sv =====
// Stack controller: count, logical capacity and resize policy, store access
// sequencing and the result register. Depends on das_pkg.
module das_ctrl #(
  parameter int unsigned STORE_DEPTH = das_pkg::StoreDepthDefault,
  localparam int unsigned AddrW = $clog2(STORE_DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [das_pkg::CountW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [das_pkg::DataW-1:0]  key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output das_pkg::result_t                  res_o,
  output logic                              mem_we_o,
  output logic                              mem_re_o,
  output logic [AddrW-1:0]                  mem_addr_o,
  output logic [das_pkg::DataW-1:0]         mem_wdata_o,
  input  logic [das_pkg::DataW-1:0]         mem_rdata_i
);

  localparam int unsigned CountW  = das_pkg::CountW;
  localparam int unsigned CapW    = das_pkg::CapW;
  localparam int unsigned ResizeW = das_pkg::ResizeW;
  localparam logic [CountW-1:0] CountLimit =
    CountW'((STORE_DEPTH < das_pkg::CountMax) ? STORE_DEPTH : das_pkg::CountMax);

  typedef enum logic {
    StIdle,
    StPopWait
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  das_pkg::result_t    res_q;
  logic [CountW-1:0]   count_q, count_d;
  logic [CapW-1:0]     cap_q, cap_d;
  logic [ResizeW-1:0]  resize_q, resize_d;

  logic                accept;
  logic                is_pop;
  logic                push_full;
  logic                pop_empty;
  logic [CountW-1:0]   count_dec;
  logic [CountW-1:0]   addr_cnt;
  logic [CountW+AddrW-1:0] addr_wide;
  logic [CapW:0]       cap_dbl;
  logic [CapW-1:0]     cap_grow;
  logic [CapW:0]       count_x4;
  logic                shrink_hit;
  logic [ResizeW-1:0]  resize_inc;

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign is_pop      = (kind_i == das_pkg::KindPop);
  assign push_full   = (count_q >= CountLimit);
  assign pop_empty   = (count_q == '0);
  assign count_dec   = count_q - CountW'(1);

  assign cap_dbl    = {cap_q, 1'b0};
  assign cap_grow   = (cap_dbl > {1'b0, das_pkg::CapMax}) ? das_pkg::CapMax : cap_dbl[CapW-1:0];
  assign count_x4   = {count_dec, 2'b00};
  assign shrink_hit = (cap_q != '0) && (count_x4 <= {1'b0, cap_q});
  assign resize_inc = (resize_q == '1) ? resize_q : resize_q + ResizeW'(1);

  // Store index: top of stack for a pop, next free slot for a push
  assign addr_cnt    = is_pop ? count_dec : count_q;
  assign addr_wide   = {{AddrW{1'b0}}, addr_cnt};
  assign mem_addr_o  = addr_wide[AddrW-1:0];
  assign mem_wdata_o = key_i;
  assign mem_we_o    = accept && !is_pop && !push_full;
  assign mem_re_o    = accept && is_pop && !pop_empty;

  always_comb begin
    count_d  = count_q;
    cap_d    = cap_q;
    resize_d = resize_q;
    if (cfg_valid_i && cfg_ready_o) begin
      cap_d   = {1'b0, cfg_data_i};
      count_d = '0;
    end
    if (mem_we_o) begin
      count_d = count_q + CountW'(1);
      if (cap_q == '0) begin
        cap_d = CapW'(1);
      end else if ({1'b0, count_q} >= cap_q) begin
        cap_d    = cap_grow;
        resize_d = resize_inc;
      end
    end
    if (mem_re_o) begin
      count_d = count_dec;
      if (shrink_hit) begin
        cap_d    = cap_q >> 1;
        resize_d = resize_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      count_q     <= '0;
      cap_q       <= das_pkg::CapReset;
      resize_q    <= '0;
    end else begin
      count_q  <= count_d;
      cap_q    <= cap_d;
      resize_q <= resize_d;
      unique case (state_q)
        StIdle: begin
          if (accept && !mem_re_o) begin
            out_valid_q        <= 1'b1;
            res_q.popped_value <= is_pop ? das_pkg::EmptyValue : '0;
            res_q.empty_flag   <= is_pop;
            res_q.full_flag    <= !is_pop && push_full;
            res_q.count        <= count_d;
            res_q.capacity     <= cap_d;
            res_q.resize_count <= resize_d;
          end else begin
            if (out_ready_i) begin
              out_valid_q <= 1'b0;
            end
            if (accept) begin
              // wait in StPopWait for the registered store read
              state_q <= StPopWait;
            end
          end
        end
        StPopWait: begin
          out_valid_q        <= 1'b1;
          res_q.popped_value <= mem_rdata_i;
          res_q.empty_flag   <= 1'b0;
          res_q.full_flag    <= 1'b0;
          res_q.count        <= count_q;
          res_q.capacity     <= cap_q;
          res_q.resize_count <= resize_q;
          state_q            <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/das_chk.sv =====
// Port-level checker for dynamic_array_stack_resizing, bound to the top level.
// Depends on das_pkg.
module das_chk #(
  parameter int unsigned STORE_DEPTH = das_pkg::StoreDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [das_pkg::CountW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [das_pkg::DataW-1:0]  key_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic signed [das_pkg::DataW-1:0]  popped_value_o,
  input  logic                              empty_flag_o,
  input  logic                              full_flag_o,
  input  logic [das_pkg::CountW-1:0]        count_o,
  input  logic [das_pkg::CapW-1:0]          capacity_o,
  input  logic [das_pkg::ResizeW-1:0]       resize_count_o
);

  localparam logic [das_pkg::CountW-1:0] CountLimit = das_pkg::CountW'(
    (STORE_DEPTH < das_pkg::CountMax) ? STORE_DEPTH : das_pkg::CountMax);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(popped_value_o)
      && $stable(count_o) && $stable(capacity_o) && $stable(resize_count_o))
    else $error("result changed while stalled");

  // An empty pop leaves a zero count and reports the empty marker
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_flag_o |->
      count_o == '0 && popped_value_o == das_pkg::EmptyValue && !full_flag_o)
    else $error("empty pop result inconsistent");

  // A refused push only happens at the count limit
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_flag_o |-> count_o == CountLimit && popped_value_o == '0)
    else $error("full push result inconsistent");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CountLimit)
    else $error("count beyond store limit");

  // Resize counter never moves backward between two results without config
  a_resize_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o |-> resize_count_o >= $past(resize_count_o))
    else $error("resize counter decreased");

endmodule

bind dynamic_array_stack_resizing das_chk #(.STORE_DEPTH(STORE_DEPTH)) u_das_chk (.*);
